>>> src/rgbhsv_pkg.sv
package rgbhsv_pkg;

  // default channel width, full scale is 2^CHANNEL_BITS - 1
  localparam int CHANNEL_BITS_DEF = 8;

  // quotient bits of every divider lane (saturation reaches 65536)
  localparam int QUO_W = 17;

  localparam int HUE_W = 15;
  localparam int Q16_W = 16;
  localparam int OUT_DATA_W = ((HUE_W + 2 * Q16_W + 7) / 8) * 8;

  // hue in 1/64 degree
  localparam int HUE_UNITS_60 = 3840;
  localparam int HUE_UNITS_360 = 23040;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } hue_sector_t;

  // per-pixel flags that ride alongside the divider lanes
  typedef struct packed {
    hue_sector_t sector;
    logic        hue_neg;   // channel difference below zero
    logic        gray;      // max equals min
    logic        black;     // max is zero
  } hsv_side_t;

endpackage

>>> src/rgbhsv_prep.sv
module rgbhsv_prep
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int REM_W = CHANNEL_BITS + QUO_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [REM_W-1:0]        hue_num,
  output logic [CHANNEL_BITS-1:0] hue_den,
  output logic [REM_W-1:0]        sat_num,
  output logic [CHANNEL_BITS-1:0] sat_den,
  output logic [Q16_W-1:0]        brightness,
  output hsv_side_t               side
);

  // copies of the max needed to fill the q0.16 brightness
  localparam int REP = (Q16_W + CHANNEL_BITS - 1) / CHANNEL_BITS;

  logic [CHANNEL_BITS-1:0]     mx;
  logic [CHANNEL_BITS-1:0]     mn;
  logic [CHANNEL_BITS-1:0]     delta;
  logic [CHANNEL_BITS:0]       diff;
  logic [CHANNEL_BITS-1:0]     diff_abs;
  logic [REP*CHANNEL_BITS-1:0] mx_rep;
  hsv_side_t                   side_next;

  always_comb begin
    // red wins ties, then green
    if (red >= green && red >= blue) begin
      mx = red;
      side_next.sector = SECTOR_RED;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      mx = green;
      side_next.sector = SECTOR_GREEN;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      mx = blue;
      side_next.sector = SECTOR_BLUE;
      diff = {1'b0, red} - {1'b0, green};
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    side_next.hue_neg = diff[CHANNEL_BITS];
    diff_abs = diff[CHANNEL_BITS] ? CHANNEL_BITS'(-diff) : diff[CHANNEL_BITS-1:0];
    side_next.gray = (delta == '0);
    side_next.black = (mx == '0);
    // mx/(2^n-1) in binary is mx repeated, full scale gives all ones (clipped value)
    mx_rep = {REP{mx}};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hue_num    <= REM_W'(diff_abs) * REM_W'(HUE_UNITS_60);
      hue_den    <= delta;
      sat_num    <= REM_W'(delta) << Q16_W;
      sat_den    <= mx;
      brightness <= mx_rep[REP*CHANNEL_BITS-1 -: Q16_W];
      side       <= side_next;
    end
  end

endmodule

>>> src/rgbhsv_div.sv
module rgbhsv_div
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int REM_W = CHANNEL_BITS + QUO_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REM_W-1:0]        in_hue_num,
  input  logic [CHANNEL_BITS-1:0] in_hue_den,
  input  logic [REM_W-1:0]        in_sat_num,
  input  logic [CHANNEL_BITS-1:0] in_sat_den,
  input  logic [Q16_W-1:0]        in_brightness,
  input  hsv_side_t               in_side,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [QUO_W-1:0]        hue_quo,
  output logic                    hue_rem_nz,
  output logic [QUO_W-1:0]        sat_quo,
  output logic [Q16_W-1:0]        brightness,
  output hsv_side_t               out_side
);

  // index 0 is the input, index s+1 the register behind stage s
  logic                    valid   [QUO_W+1];
  logic                    ready   [QUO_W+1];
  logic [REM_W-1:0]        hue_rem [QUO_W+1];
  logic [CHANNEL_BITS-1:0] hue_den [QUO_W+1];
  logic [QUO_W-1:0]        hue_q   [QUO_W+1];
  logic [REM_W-1:0]        sat_rem [QUO_W+1];
  logic [CHANNEL_BITS-1:0] sat_den [QUO_W+1];
  logic [QUO_W-1:0]        sat_q   [QUO_W+1];
  logic [Q16_W-1:0]        bright  [QUO_W+1];
  hsv_side_t               side    [QUO_W+1];

  assign valid[0]   = in_valid;
  assign in_ready   = ready[0];
  assign hue_rem[0] = in_hue_num;
  assign hue_den[0] = in_hue_den;
  assign hue_q[0]   = '0;
  assign sat_rem[0] = in_sat_num;
  assign sat_den[0] = in_sat_den;
  assign sat_q[0]   = '0;
  assign bright[0]  = in_brightness;
  assign side[0]    = in_side;

  assign ready[QUO_W] = out_ready;

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int J = QUO_W - 1 - s;

    logic [REM_W-1:0] hue_trial;
    logic [REM_W-1:0] sat_trial;
    logic             hue_ge;
    logic             sat_ge;

    always_comb begin
      hue_trial = REM_W'(hue_den[s]) << J;
      sat_trial = REM_W'(sat_den[s]) << J;
      hue_ge = hue_rem[s] >= hue_trial;
      sat_ge = sat_rem[s] >= sat_trial;
    end

    assign ready[s] = !valid[s+1] || ready[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (ready[s]) begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (valid[s] && ready[s]) begin
        hue_rem[s+1] <= hue_ge ? hue_rem[s] - hue_trial : hue_rem[s];
        sat_rem[s+1] <= sat_ge ? sat_rem[s] - sat_trial : sat_rem[s];
        hue_q[s+1]   <= hue_q[s] | (QUO_W'(hue_ge) << J);
        sat_q[s+1]   <= sat_q[s] | (QUO_W'(sat_ge) << J);
        hue_den[s+1] <= hue_den[s];
        sat_den[s+1] <= sat_den[s];
        bright[s+1]  <= bright[s];
        side[s+1]    <= side[s];
      end
    end
  end

  assign out_valid  = valid[QUO_W];
  assign hue_quo    = hue_q[QUO_W];
  assign hue_rem_nz = (hue_rem[QUO_W] != '0);
  assign sat_quo    = sat_q[QUO_W];
  assign brightness = bright[QUO_W];
  assign out_side   = side[QUO_W];

endmodule

>>> src/rgbhsv_out.sv
module rgbhsv_out
  import rgbhsv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [QUO_W-1:0]      hue_quo,
  input  logic                  hue_rem_nz,
  input  logic [QUO_W-1:0]      sat_quo,
  input  logic [Q16_W-1:0]      brightness,
  input  hsv_side_t             side,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [QUO_W-1:0] hue_base;
  logic [QUO_W-1:0] hue_sum;
  logic [HUE_W-1:0] hue;
  logic [Q16_W-1:0] saturation;

  always_comb begin
    unique case (side.sector)
      SECTOR_RED:   hue_base = '0;
      SECTOR_GREEN: hue_base = QUO_W'(2 * HUE_UNITS_60);
      SECTOR_BLUE:  hue_base = QUO_W'(4 * HUE_UNITS_60);
      default:      hue_base = '0;
    endcase
    // floor of a negative fraction rounds away from zero
    if (side.hue_neg) begin
      hue_sum = hue_base - hue_quo - QUO_W'(hue_rem_nz);
    end else begin
      hue_sum = hue_base + hue_quo;
    end
    if (hue_sum[QUO_W-1]) begin
      hue_sum = hue_sum + QUO_W'(HUE_UNITS_360);
    end
    hue = side.gray ? '0 : hue_sum[HUE_W-1:0];

    if (side.black) begin
      saturation = '0;
    end else begin
      saturation = sat_quo[QUO_W-1] ? '1 : sat_quo[Q16_W-1:0];
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_tdata <= OUT_DATA_W'({brightness, saturation, hue});
    end
  end

endmodule

>>> src/rgb_to_hsv_converter.sv
// rgb to hsv pixel converter: takes one rgb pixel per beat and returns one hsv
// beat per pixel, in order. hue is in 1/64 degree (0 to 23039), saturation is
// max-min over max and brightness is max over full scale, both q0.16 and
// clipped at 65535. a gray pixel gives hue 0, a black pixel saturation 0;
// ties for the maximum go to red, then green. throughput is one pixel per
// cycle with no gaps while m_tready holds high. an input beat passes through
// a register for max/min, operand setup and brightness (the max bit pattern
// repeated), the restoring dividers (one quotient bit per stage, hue and
// saturation in parallel lanes, brightness riding alongside) and the output
// register, which takes the hue assembly and clipping. each stage holds its
// own valid bit and stalls only when the stage behind it is full, so empty
// slots are squeezed out under back pressure.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int IN_DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // rgb pixel in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // red, green, blue, zero fill
  // hsv result out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // hue, saturation, brightness, zero fill
);

  localparam int REM_W = CHANNEL_BITS + QUO_W;

  // channel fields of the input beat
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  assign red   = s_tdata[CHANNEL_BITS-1:0];
  assign green = s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
  assign blue  = s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

  // setup stage to divider
  logic                    prep_valid;
  logic                    prep_ready;
  logic [REM_W-1:0]        prep_hue_num;
  logic [CHANNEL_BITS-1:0] prep_hue_den;
  logic [REM_W-1:0]        prep_sat_num;
  logic [CHANNEL_BITS-1:0] prep_sat_den;
  logic [Q16_W-1:0]        prep_brightness;
  hsv_side_t               prep_side;

  // divider to output stage
  logic                    div_valid;
  logic                    div_ready;
  logic [QUO_W-1:0]        div_hue_quo;
  logic                    div_hue_rem_nz;
  logic [QUO_W-1:0]        div_sat_quo;
  logic [Q16_W-1:0]        div_brightness;
  hsv_side_t               div_side;

  // max/min, hue sector, brightness and divider operands
  rgbhsv_prep #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (prep_valid),
    .out_ready  (prep_ready),
    .hue_num    (prep_hue_num),
    .hue_den    (prep_hue_den),
    .sat_num    (prep_sat_num),
    .sat_den    (prep_sat_den),
    .brightness (prep_brightness),
    .side       (prep_side)
  );

  // two-lane pipelined divider
  rgbhsv_div #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (prep_valid),
    .in_ready      (prep_ready),
    .in_hue_num    (prep_hue_num),
    .in_hue_den    (prep_hue_den),
    .in_sat_num    (prep_sat_num),
    .in_sat_den    (prep_sat_den),
    .in_brightness (prep_brightness),
    .in_side       (prep_side),
    .out_valid     (div_valid),
    .out_ready     (div_ready),
    .hue_quo       (div_hue_quo),
    .hue_rem_nz    (div_hue_rem_nz),
    .sat_quo       (div_sat_quo),
    .brightness    (div_brightness),
    .out_side      (div_side)
  );

  // hue wrap, clipping and output register
  rgbhsv_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .in_ready   (div_ready),
    .hue_quo    (div_hue_quo),
    .hue_rem_nz (div_hue_rem_nz),
    .sat_quo    (div_sat_quo),
    .brightness (div_brightness),
    .side       (div_side),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> tb/rgb_to_hsv_converter_test.sv
module rgb_to_hsv_converter_test;
  import rgbhsv_pkg::*;

  localparam int CH_BITS = CHANNEL_BITS_DEF;
  localparam int FULL_SCALE = (1 << CH_BITS) - 1;
  localparam int IN_W = ((3 * CH_BITS + 7) / 8) * 8;
  localparam int Q16_MAX = 65535;
  localparam int RANDOM_PIXELS = 1200;
  localparam int CYCLE_LIMIT = 200000;
  // long receiver hold-off, starts once this many pixels went in
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;
  // pipeline depth plus margin, for the drain at the end
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } rgb_pixel_t;

  typedef struct packed {
    logic [Q16_W-1:0] brightness;
    logic [Q16_W-1:0] saturation;
    logic [HUE_W-1:0] hue;
  } hsv_pixel_t;

  // expected hsv pixels in input order, with its own copy of the conversion
  class hsv_scoreboard;
    hsv_pixel_t hsv_q[$];
    int         errors = 0;
    int         accepted = 0;

    function hsv_pixel_t convert(rgb_pixel_t px);
      int          r, g, b, mx, mn, d, k, diff, num, h, s, v;
      hue_sector_t sector;
      hsv_pixel_t  res;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      h = 0;
      if (d != 0) begin
        // ties go to red, then green
        if (mx == r) sector = SECTOR_RED;
        else if (mx == g) sector = SECTOR_GREEN;
        else sector = SECTOR_BLUE;
        case (sector)
          SECTOR_RED: begin
            k = 0;
            diff = g - b;
          end
          SECTOR_GREEN: begin
            k = 2;
            diff = b - r;
          end
          default: begin
            k = 4;
            diff = r - g;
          end
        endcase
        num = HUE_UNITS_60 * (k * d + diff);
        // floor division, the language truncates toward zero
        if (num >= 0) h = num / d;
        else h = -((-num + d - 1) / d);
        if (h < 0) h += HUE_UNITS_360;
      end
      s = 0;
      if (mx != 0) begin
        s = (d * 65536) / mx;
        if (s > Q16_MAX) s = Q16_MAX;
      end
      v = (mx * 65536) / FULL_SCALE;
      if (v > Q16_MAX) v = Q16_MAX;
      res.hue = h[HUE_W-1:0];
      res.saturation = s[Q16_W-1:0];
      res.brightness = v[Q16_W-1:0];
      return res;
    endfunction

    function void note_pixel(rgb_pixel_t px);
      hsv_q.push_back(convert(px));
      accepted++;
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data);
      hsv_pixel_t got, want;
      got = data[HUE_W+2*Q16_W-1:0];
      if (hsv_q.size() == 0) begin
        $error("hsv beat with no pixel outstanding: %h", data);
        errors++;
        return;
      end
      want = hsv_q.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
        errors++;
      end
      if (got.brightness !== want.brightness) begin
        $error("brightness: expected %0d, got %0d", want.brightness, got.brightness);
        errors++;
      end
    endfunction

    function int pending();
      return hsv_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;   // red, green, blue
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // hue, saturation, brightness, zero fill

  hsv_scoreboard sb = new;
  int            cycles = 0;

  rgb_to_hsv_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // every accepted hsv beat is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata);
  end

  // burst bookkeeping of the pixel sender
  int burst_left = 0;

  // offer one pixel and hold it until the block takes the beat; called right
  // after a rising edge, so valid stays high across back-to-back pixels
  task automatic send_pixel(rgb_pixel_t px);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      // some bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [CH_BITS-1:0] edge_code();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CH_BITS'(1);
      2: return CH_BITS'(FULL_SCALE - 1);
      3: return CH_BITS'(FULL_SCALE);
      default: return CH_BITS'($urandom_range(0, FULL_SCALE));
    endcase
  endfunction

  // mostly plain random colors, with plenty of ties, grays and channel extremes
  function automatic rgb_pixel_t random_pixel();
    rgb_pixel_t px;
    logic [CH_BITS-1:0] a, c;
    int step;
    px.red = CH_BITS'($urandom_range(0, FULL_SCALE));
    px.green = CH_BITS'($urandom_range(0, FULL_SCALE));
    px.blue = CH_BITS'($urandom_range(0, FULL_SCALE));
    case ($urandom_range(0, 9))
      0, 1: begin
        px.red = edge_code();
        px.green = edge_code();
        px.blue = edge_code();
      end
      2, 3: begin
        // two channels tie for the maximum
        a = CH_BITS'($urandom_range(0, FULL_SCALE));
        c = CH_BITS'($urandom_range(0, a));
        case ($urandom_range(0, 2))
          0: px = '{blue: c, green: a, red: a};
          1: px = '{blue: a, green: a, red: c};
          default: px = '{blue: a, green: c, red: a};
        endcase
      end
      4: begin
        // gray or near gray
        a = CH_BITS'($urandom_range(0, FULL_SCALE));
        step = $urandom_range(0, 1);
        px.red = a;
        px.green = CH_BITS'((a + step <= FULL_SCALE) ? a + step : a);
        px.blue = a;
      end
      default: ;
    endcase
    return px;
  endfunction

  // receiver: a changing series of stall patterns, plus one long
  // hold-off that lets the pipeline fill up and push back on the sender
  initial begin : receiver
    int  mode, len;
    bit  held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && sb.accepted >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 120);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (i % 4) != 3;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    rgb_pixel_t directed[$];
    directed = '{
      '{blue: 8'd0,   green: 8'd0,   red: 8'd0},    // black
      '{blue: 8'd255, green: 8'd255, red: 8'd255},  // white, full-scale max
      '{blue: 8'd128, green: 8'd128, red: 8'd128},  // gray
      '{blue: 8'd1,   green: 8'd1,   red: 8'd1},
      '{blue: 8'd0,   green: 8'd0,   red: 8'd255},  // pure red
      '{blue: 8'd0,   green: 8'd255, red: 8'd0},    // pure green
      '{blue: 8'd255, green: 8'd0,   red: 8'd0},    // pure blue
      '{blue: 8'd1,   green: 8'd0,   red: 8'd255},  // red max, hue wraps below zero
      '{blue: 8'd200, green: 8'd10,  red: 8'd201},
      '{blue: 8'd0,   green: 8'd255, red: 8'd255},  // red ties green
      '{blue: 8'd255, green: 8'd255, red: 8'd0},    // green ties blue
      '{blue: 8'd255, green: 8'd0,   red: 8'd255},  // red ties blue
      '{blue: 8'd9,   green: 8'd100, red: 8'd100},
      '{blue: 8'd0,   green: 8'd0,   red: 8'd1},    // pure chroma, small max
      '{blue: 8'd0,   green: 8'd1,   red: 8'd0},
      '{blue: 8'd1,   green: 8'd0,   red: 8'd0},
      '{blue: 8'd255, green: 8'd253, red: 8'd254},
      '{blue: 8'd253, green: 8'd255, red: 8'd254},
      '{blue: 8'd2,   green: 8'd0,   red: 8'd1},    // blue max, red above green
      '{blue: 8'd2,   green: 8'd1,   red: 8'd0},    // blue max, hue 210 degrees
      '{blue: 8'd170, green: 8'd85,  red: 8'd85},
      '{blue: 8'd254, green: 8'd127, red: 8'd0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_pixel(directed[i]);
    for (int i = 0; i < RANDOM_PIXELS; i++) send_pixel(random_pixel());
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // stray beats after the last expected one still get flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
